// File: rtl/core/lbct_pkg.sv
// Shared constants, types and helpers of the block cache tag controller.
`default_nettype none

package lbct_pkg;

  localparam int unsigned SLOTS        = 8;
  localparam int unsigned IDX_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned AGE_W        = 32;
  localparam int unsigned FUNC_W       = 2;
  localparam int unsigned SLOT_FIELD_W = 3;
  localparam int unsigned PDATA_W      = 32;
  localparam int unsigned PADDR_W      = 3;
  localparam int unsigned REG_IDX_W    = PADDR_W - 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_INVAL = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  localparam logic [REG_IDX_W-1:0] REG_PART_OFS = '0;

  typedef logic [IDX_W-1:0] idx_t;

  // Control of the shared scan unit from the sequencer.
  typedef struct packed {
    logic step;
    logic first;
  } lbct_scan_ctl_t;

  // Running result of the scan unit.
  typedef struct packed {
    logic found;
    idx_t match_idx;
    idx_t victim_idx;
  } lbct_scan_res_t;

  // The slot field keeps the low bits of the slot index only.
  function automatic logic [SLOT_FIELD_W-1:0] slot_field(idx_t idx);
    logic [IDX_W+SLOT_FIELD_W-1:0] ext;
    ext = {{SLOT_FIELD_W{1'b0}}, idx};
    return ext[SLOT_FIELD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/lbct_if.sv
// Request and response channel interfaces of the block cache tag controller.
`default_nettype none

interface lbct_req_if import lbct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ADDR_W-1:0] block_addr;
  logic              card_ok;

  modport source (output valid, func, block_addr, card_ok, input ready);
  modport sink (input valid, func, block_addr, card_ok, output ready);
endinterface

interface lbct_rsp_if import lbct_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic [SLOT_FIELD_W-1:0] slot;
  logic                    fill;
  logic                    card_access;
  logic [ADDR_W-1:0]       card_addr;
  logic                    status;

  modport source (output valid, hit, slot, fill, card_access, card_addr, status,
                  input ready);
  modport sink (input valid, hit, slot, fill, card_access, card_addr, status,
                output ready);
endinterface

`default_nettype wire

// File: rtl/core/lbct_cfg.sv
// APB-style configuration register file holding the partition offset.
`default_nettype none

module lbct_cfg import lbct_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output logic      [ADDR_W-1:0]  part_ofs_o
);

  logic [ADDR_W-1:0] part_ofs_q;
  logic              sel_ofs;

  assign pready  = 1'b1;
  assign sel_ofs = (paddr[PADDR_W-1:2] == REG_PART_OFS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_ofs_q <= '0;
    end else if (psel && penable && pwrite && pready && sel_ofs) begin
      part_ofs_q <= pwdata[ADDR_W-1:0];
    end
  end

  assign prdata     = sel_ofs ? part_ofs_q : '0;
  assign part_ofs_o = part_ofs_q;

endmodule

`default_nettype wire

// File: rtl/core/lbct_scan.sv
// Shared scan unit: one tag compare and one age compare per step.
`default_nettype none

module lbct_scan import lbct_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire lbct_scan_ctl_t ctl_i,
  input  wire idx_t           idx_i,
  input  wire logic           ent_valid_i,
  input  wire logic [ADDR_W-1:0] ent_tag_i,
  input  wire logic [AGE_W-1:0]  ent_age_i,
  input  wire logic [ADDR_W-1:0] key_i,
  output lbct_scan_res_t      res_o
);

  logic             found_q;
  idx_t             match_idx_q;
  idx_t             victim_idx_q;
  logic [AGE_W-1:0] best_age_q;
  logic             match;
  logic             older;

  assign match = ent_valid_i && (ent_tag_i == key_i);
  assign older = ent_age_i < best_age_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.step) begin
      // The first match in index order wins, so later duplicates are ignored.
      if (ctl_i.first) begin
        found_q <= match;
      end else if (match) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.step) begin
      if (match && (ctl_i.first || !found_q)) begin
        match_idx_q <= idx_i;
      end
      // Strict compare keeps the lowest index among equal ages.
      if (ctl_i.first || older) begin
        best_age_q   <= ent_age_i;
        victim_idx_q <= idx_i;
      end
    end
  end

  assign res_o.found      = found_q;
  assign res_o.match_idx  = match_idx_q;
  assign res_o.victim_idx = victim_idx_q;

endmodule

`default_nettype wire

// File: rtl/core/lru_block_cache_tags_unit.sv
// Top level of the block cache tag controller: sequencer, tag store and replacement.
`default_nettype none

// Tag and replacement controller for a fully associative, write-through,
// no-write-allocate block cache with SLOTS slots. A request reads a block,
// writes a block or invalidates every slot; the card address is the block
// address plus the partition offset register, modulo 2^32. Replacement is
// least recently used: every touched slot takes the next value of a wrapping
// 32-bit age counter, and a read miss fills the slot with the lowest age,
// lowest index on ties. Each request yields exactly one response item. The
// block works on one item at a time: after the item is accepted, a single
// shared compare unit walks the slots one per cycle (tag match and age
// minimum together), then the update state writes the tag store and forms
// the response, which is held in the output register until taken; only
// then is the next request accepted. An invalidate or an unused function
// code skips the walk and goes straight to the update state. The data
// payload is kept outside, in a memory addressed by the reported slot.
module lru_block_cache_tags_unit import lbct_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  lbct_req_if.sink                req_i,
  lbct_rsp_if.source              rsp_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESP
  } st_e;

  localparam idx_t IDX_LAST = idx_t'(SLOTS - 1);

  st_e               state_q;
  idx_t              scan_idx_q;
  logic [SLOTS-1:0]  valid_q;
  logic [AGE_W-1:0]  age_q [SLOTS];
  logic [ADDR_W-1:0] tag_q [SLOTS];
  logic [AGE_W-1:0]  age_cnt_q;

  // Captured request.
  logic [FUNC_W-1:0] req_func_q;
  logic [ADDR_W-1:0] req_addr_q;
  logic              req_ok_q;

  // Response register.
  logic              rsp_hit_q;
  idx_t              rsp_slot_q;
  logic              rsp_fill_q;
  logic              rsp_acc_q;
  logic [ADDR_W-1:0] rsp_caddr_q;
  logic              rsp_status_q;

  logic [ADDR_W-1:0] part_ofs;
  lbct_scan_ctl_t    scan_ctl;
  lbct_scan_res_t    scan_res;
  logic              req_acc;

  // Decisions made in the update cycle.
  logic              touch_en;
  idx_t              touch_idx;
  logic              fill_en;
  logic              inval_en;
  logic              hit_d;
  idx_t              slot_d;
  logic              fill_d;
  logic              acc_d;
  logic [ADDR_W-1:0] caddr_d;
  logic              status_d;
  logic [ADDR_W-1:0] caddr_sum;
  logic [AGE_W-1:0]  age_next;

  lbct_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .part_ofs_o (part_ofs)
  );

  assign scan_ctl.step  = (state_q == ST_SCAN);
  assign scan_ctl.first = (scan_idx_q == '0);

  lbct_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (scan_ctl),
    .idx_i       (scan_idx_q),
    .ent_valid_i (valid_q[scan_idx_q]),
    .ent_tag_i   (tag_q[scan_idx_q]),
    .ent_age_i   (age_q[scan_idx_q]),
    .key_i       (req_addr_q),
    .res_o       (scan_res)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;

  assign caddr_sum = req_addr_q + part_ofs;
  assign age_next  = age_cnt_q + AGE_W'(1);

  // Outcome of the request once the walk over the slots is complete.
  always_comb begin
    touch_en  = 1'b0;
    touch_idx = scan_res.match_idx;
    fill_en   = 1'b0;
    inval_en  = 1'b0;
    hit_d     = 1'b0;
    slot_d    = '0;
    fill_d    = 1'b0;
    acc_d     = 1'b0;
    caddr_d   = '0;
    status_d  = 1'b0;
    unique case (func_e'(req_func_q))
      FUNC_READ: begin
        if (scan_res.found) begin
          touch_en = 1'b1;
          hit_d    = 1'b1;
          slot_d   = scan_res.match_idx;
        end else begin
          acc_d   = 1'b1;
          caddr_d = caddr_sum;
          if (!req_ok_q) begin
            status_d = 1'b1;
          end else begin
            fill_en   = 1'b1;
            touch_en  = 1'b1;
            touch_idx = scan_res.victim_idx;
            slot_d    = scan_res.victim_idx;
            fill_d    = 1'b1;
          end
        end
      end
      FUNC_WRITE: begin
        acc_d   = 1'b1;
        caddr_d = caddr_sum;
        if (!req_ok_q) begin
          status_d = 1'b1;
        end else if (scan_res.found) begin
          touch_en = 1'b1;
          hit_d    = 1'b1;
          slot_d   = scan_res.match_idx;
          fill_d   = 1'b1;
        end
      end
      FUNC_INVAL: begin
        inval_en = 1'b1;
      end
      FUNC_NONE: begin
        inval_en = 1'b0;
      end
      default: begin
        inval_en = 1'b0;
      end
    endcase
  end

  // Sequencer, valid bits, ages and the age counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      scan_idx_q <= '0;
      valid_q    <= '0;
      age_cnt_q  <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (req_acc) begin
            scan_idx_q <= '0;
            if ((func_e'(req_i.func) == FUNC_READ) ||
                (func_e'(req_i.func) == FUNC_WRITE)) begin
              state_q <= ST_SCAN;
            end else begin
              state_q <= ST_UPDATE;
            end
          end
        end
        ST_SCAN: begin
          if (scan_idx_q == IDX_LAST) begin
            state_q <= ST_UPDATE;
          end else begin
            scan_idx_q <= scan_idx_q + idx_t'(1);
          end
        end
        ST_UPDATE: begin
          state_q <= ST_RESP;
          if (inval_en) begin
            valid_q   <= '0;
            age_cnt_q <= '0;
            for (int i = 0; i < SLOTS; i++) begin
              age_q[i] <= '0;
            end
          end else begin
            if (touch_en) begin
              age_cnt_q        <= age_next;
              age_q[touch_idx] <= age_next;
            end
            if (fill_en) begin
              valid_q[scan_res.victim_idx] <= 1'b1;
            end
          end
        end
        ST_RESP: begin
          if (rsp_o.ready) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Tags, the captured request and the response register need no reset:
  // a tag is only looked at behind its valid bit.
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      req_func_q <= req_i.func;
      req_addr_q <= req_i.block_addr;
      req_ok_q   <= req_i.card_ok;
    end
    if (state_q == ST_UPDATE) begin
      if (fill_en) begin
        tag_q[scan_res.victim_idx] <= req_addr_q;
      end
      rsp_hit_q    <= hit_d;
      rsp_slot_q   <= slot_d;
      rsp_fill_q   <= fill_d;
      rsp_acc_q    <= acc_d;
      rsp_caddr_q  <= caddr_d;
      rsp_status_q <= status_d;
    end
  end

  assign rsp_o.valid       = (state_q == ST_RESP);
  assign rsp_o.hit         = rsp_hit_q;
  assign rsp_o.slot        = slot_field(rsp_slot_q);
  assign rsp_o.fill        = rsp_fill_q;
  assign rsp_o.card_access = rsp_acc_q;
  assign rsp_o.card_addr   = rsp_caddr_q;
  assign rsp_o.status      = rsp_status_q;

  // A new request is never taken while a response is still held.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rsp_o.valid && req_i.ready))
    else $error("request accepted while a response is pending");

  // A failed card transfer leaves hit and fill low.
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status) |-> (rsp_o.card_access && !rsp_o.hit && !rsp_o.fill))
    else $error("failed card access reported a hit or fill");

  // A fill without a hit comes only from a read miss served by the card.
  a_fill_card: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.fill && !rsp_o.hit) |-> rsp_o.card_access)
    else $error("slot fill without card access");

  // An invalidate clears every valid bit and the age counter.
  a_inval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && (func_e'(req_i.func) == FUNC_INVAL)) |-> ##2
      ((valid_q == '0) && (age_cnt_q == '0)))
    else $error("invalidate left a slot valid");

endmodule

`default_nettype wire
